@@ hdl/satfo_pkg.sv @@
// ----------------------------------------------------------------------------
// satfo_pkg: shared types and constants for the section address translator
// Section descriptor layout, command and register codes, reset values.
// ----------------------------------------------------------------------------
package satfo_pkg;

    // Table geometry
    localparam int MAX_SECTIONS_DEF = 128;
    localparam int CMP_W            = 17;  // wide enough for a table depth up to 2**17 - 1

    // Stream payload widths
    localparam int S_TDATA_W = 168;  // 167 bits of fields, padded to bytes
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 40;   // 33-bit offset, padded to bytes
    localparam int M_TUSER_W = 1;
    localparam int OFFSET_W  = 33;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef logic [CFG_IDX_W-1:0] t_cfg_index;
    localparam t_cfg_index CFG_SECTION_COUNT = 2'd0;
    localparam t_cfg_index CFG_FILE_ALIGN    = 2'd1;
    localparam t_cfg_index CFG_SECTION_ALIGN = 2'd2;

    localparam logic [7:0] RST_SECTION_COUNT = 8'd0;
    localparam logic [4:0] RST_FILE_ALIGN    = 5'd9;
    localparam logic [4:0] RST_SECTION_ALIGN = 5'd12;

    // Commands carried in tuser
    typedef logic t_cmd;
    localparam t_cmd CMD_WRITE     = 1'b0;
    localparam t_cmd CMD_TRANSLATE = 1'b1;

    // Address constants
    localparam logic [31:0] PAGE_MASK       = 32'h0000_0FFF;
    localparam logic [31:0] RAW_GRAIN_MASK  = 32'h0000_01FF;
    localparam logic [4:0]  PAGE_ALIGN_LOG2 = 5'd12;

    // One section descriptor as stored in the table
    typedef struct packed {
        logic [31:0] rptr;
        logic [31:0] rsize;
        logic [31:0] vsize;
        logic [31:0] base;
    } t_sect;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

endpackage

@@ hdl/section_address_to_file_offset.sv @@
// Flow: a write item or a translation with no sections moves its result from the
// result holding register to the output register; a translation reads entries from
// 0 through stages 1 and 2, at most min(section_count, MAX_SECTIONS) entries,
// and stops at the first entry that decides it. One item at a time: the next
// item is accepted only once the last result has moved to the output register.
// Reset: configuration returns to its defaults; the table is not cleared.
// ----------------------------------------------------------------------------
// section_address_to_file_offset: section table and address translator
// Stores section descriptors in a synchronous memory and walks them to turn
// a relative virtual address into a file offset.
// ----------------------------------------------------------------------------
module section_address_to_file_offset #(
    parameter int MAX_SECTIONS = satfo_pkg::MAX_SECTIONS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [6:0] entry_index, [38:7] section_base, [70:39] section_virtual_size,
    // [102:71] section_raw_size, [134:103] section_raw_pointer,
    // [166:135] query_address, [167] zero
    input  logic [satfo_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] command
    input  logic [satfo_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    // Result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [32:0] file_offset, [39:33] zero
    output logic [satfo_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // [0] found
    output logic [satfo_pkg::M_TUSER_W-1:0]  o_m_axis_tuser,
    // Configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [satfo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [satfo_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
    localparam int CMP_W = satfo_pkg::CMP_W;
    localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_SECTIONS);

    // ------------------------------------------------------------------
    // Payload fields
    // ------------------------------------------------------------------
    logic [6:0]       s_entry_index;
    satfo_pkg::t_sect s_sect;
    logic [31:0]      s_query;
    satfo_pkg::t_cmd  s_cmd;

    assign s_entry_index = i_s_axis_tdata[6:0];
    assign s_sect.base   = i_s_axis_tdata[38:7];
    assign s_sect.vsize  = i_s_axis_tdata[70:39];
    assign s_sect.rsize  = i_s_axis_tdata[102:71];
    assign s_sect.rptr   = i_s_axis_tdata[134:103];
    assign s_query       = i_s_axis_tdata[166:135];
    assign s_cmd         = i_s_axis_tuser[0];

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] r_section_count;
    logic [4:0] r_file_align_log2;
    logic [4:0] r_section_align_log2;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section_count      <= satfo_pkg::RST_SECTION_COUNT;
            r_file_align_log2    <= satfo_pkg::RST_FILE_ALIGN;
            r_section_align_log2 <= satfo_pkg::RST_SECTION_ALIGN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                satfo_pkg::CFG_SECTION_COUNT: r_section_count      <= i_cfg_data;
                satfo_pkg::CFG_FILE_ALIGN:    r_file_align_log2    <= i_cfg_data[4:0];
                satfo_pkg::CFG_SECTION_ALIGN: r_section_align_log2 <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    satfo_pkg::t_state r_state, n_state;
    logic              s_acc;
    logic              issue;
    logic              finish;
    logic              out_load;
    logic              mem_we;
    logic              rd_en;

    logic [31:0]       r_va;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_issue_idx;

    logic              r_res_found;
    logic [satfo_pkg::OFFSET_W-1:0] r_res_offset;

    logic              r_out_vld;
    logic              r_out_found;
    logic [satfo_pkg::OFFSET_W-1:0] r_out_offset;

    // Effective walk length and write address checks
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] wr_ext;
    logic [CNT_W-1:0] n_eff;
    logic             wr_in_range;

    assign count_ext   = CMP_W'(r_section_count);
    assign wr_ext      = CMP_W'(s_entry_index);
    assign n_eff       = (count_ext < MAX_EXT) ? count_ext[CNT_W-1:0]
                                               : MAX_EXT[CNT_W-1:0];
    assign wr_in_range = (wr_ext < MAX_EXT);

    // ------------------------------------------------------------------
    // Section table memory: one write port, one registered read port
    // ------------------------------------------------------------------
    satfo_pkg::t_sect mem [MAX_SECTIONS];
    satfo_pkg::t_sect r_rd_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_ext[IDX_W-1:0]] <= s_sect;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[r_issue_idx[IDX_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: span, bounds and raw start of the entry just read
    // ------------------------------------------------------------------
    logic        r_s1_vld, r_s1_first, r_s1_last;
    logic [31:0] fa_mask;
    logic [31:0] raw_span, virt_span, span;
    logic [31:0] rstart;

    assign fa_mask   = (32'd1 << r_file_align_log2) - 32'd1;
    assign raw_span  = (r_rd_data.rsize + fa_mask) & ~fa_mask;
    assign virt_span = (r_rd_data.vsize + satfo_pkg::PAGE_MASK) & ~satfo_pkg::PAGE_MASK;

    always_comb begin
        if (r_rd_data.vsize != 32'd0) begin
            span = (virt_span < raw_span) ? virt_span : raw_span;
        end else begin
            span = raw_span;
        end
    end

    assign rstart = (r_section_align_log2 >= satfo_pkg::PAGE_ALIGN_LOG2)
                  ? (r_rd_data.rptr & ~satfo_pkg::RAW_GRAIN_MASK)
                  : r_rd_data.rptr;

    // ------------------------------------------------------------------
    // Stage 2: span end, hit test and decision
    // ------------------------------------------------------------------
    logic        r_s2_vld, r_s2_first, r_s2_last, r_s2_below, r_s2_raw;
    logic [31:0] r_s2_base, r_s2_span, r_s2_diff, r_s2_rstart;
    logic [31:0] span_end;
    logic        hit;
    logic        dec_found;
    logic [satfo_pkg::OFFSET_W-1:0] dec_offset;

    assign span_end = r_s2_base + r_s2_span;
    assign hit      = r_s2_raw && (r_va < span_end);

    always_comb begin
        dec_found  = 1'b0;
        dec_offset = '0;
        if (r_s2_below) begin
            dec_found  = r_s2_first;
            dec_offset = r_s2_first ? satfo_pkg::OFFSET_W'(r_va) : '0;
        end else if (hit) begin
            dec_found  = 1'b1;
            dec_offset = satfo_pkg::OFFSET_W'(r_s2_diff)
                       + satfo_pkg::OFFSET_W'(r_s2_rstart);
        end
    end

    assign finish = r_s2_vld && (r_s2_below || hit || r_s2_last);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            satfo_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (s_cmd == satfo_pkg::CMD_TRANSLATE && n_eff != '0) begin
                        n_state = satfo_pkg::ST_WALK;
                    end else begin
                        n_state = satfo_pkg::ST_DONE;
                    end
                end
            end
            satfo_pkg::ST_WALK: begin
                if (finish) begin
                    n_state = satfo_pkg::ST_DONE;
                end
            end
            satfo_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = satfo_pkg::ST_IDLE;
                end
            end
            default: n_state = satfo_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_s_axis_tready = 1'b0;
        issue           = 1'b0;
        out_load        = 1'b0;
        case (r_state)
            satfo_pkg::ST_IDLE: o_s_axis_tready = 1'b1;
            satfo_pkg::ST_WALK: issue = (r_issue_idx < r_n) && !finish;
            satfo_pkg::ST_DONE: out_load = !r_out_vld || i_m_axis_tready;
            default: ;
        endcase
    end

    assign s_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign mem_we = s_acc && (s_cmd == satfo_pkg::CMD_WRITE) && wr_in_range;
    assign rd_en  = issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= satfo_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Latch the query and walk length; advance the read pointer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_va <= s_query;
            r_n  <= n_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_idx <= '0;
        end else if (s_acc) begin
            r_issue_idx <= '0;
        end else if (issue) begin
            r_issue_idx <= r_issue_idx + CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Walk pipeline valids; drop anything in flight once a decision is made
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld && !finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_first <= (r_issue_idx == '0);
            r_s1_last  <= (({1'b0, r_issue_idx} + (CNT_W + 1)'(1)) == {1'b0, r_n});
        end
        if (r_s1_vld) begin
            r_s2_first  <= r_s1_first;
            r_s2_last   <= r_s1_last;
            r_s2_below  <= (r_va < r_rd_data.base);
            r_s2_raw    <= (r_rd_data.rptr != 32'd0);
            r_s2_base   <= r_rd_data.base;
            r_s2_span   <= span;
            r_s2_diff   <= r_va - r_rd_data.base;
            r_s2_rstart <= rstart;
        end
    end

    // ------------------------------------------------------------------
    // Result holding register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            if (s_cmd == satfo_pkg::CMD_WRITE) begin
                r_res_found  <= 1'b0;
                r_res_offset <= '0;
            end else begin
                r_res_found  <= 1'b1;
                r_res_offset <= satfo_pkg::OFFSET_W'(s_query);
            end
        end else if (r_state == satfo_pkg::ST_WALK && finish) begin
            r_res_found  <= dec_found;
            r_res_offset <= dec_offset;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_found  <= r_res_found;
            r_out_offset <= r_res_offset;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = satfo_pkg::M_TDATA_W'(r_out_offset);
    assign o_m_axis_tuser  = satfo_pkg::M_TUSER_W'(r_out_found);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_write_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && s_cmd == satfo_pkg::CMD_WRITE
        |=> r_state == satfo_pkg::ST_DONE && !r_res_found && r_res_offset == '0)
        else $error("write item did not produce an empty acknowledge");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == satfo_pkg::ST_WALK |-> r_issue_idx <= r_n)
        else $error("read pointer ran past the walk length");

    a_pipe_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> $past(r_state) == satfo_pkg::ST_WALK)
        else $error("walk pipeline valid outside a walk");

    a_done_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_vld && r_state == satfo_pkg::ST_IDLE)
        else $error("result did not move to the output register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_m_axis_tready |-> !out_load)
        else $error("output register overwritten while stalled");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for section_address_to_file_offset
// Loads section descriptors and translates addresses through the stream
// ports, predicts every result with a local copy of the table and the
// registers, and compares each result against the oldest prediction.
// Directed cases come first, then randomized section layouts under many
// register settings, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TABLE_DEPTH   = satfo_pkg::MAX_SECTIONS_DEF;
    localparam int RANDOM_ITEMS  = 800;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 1500000;

    // Register index with no register behind it
    localparam satfo_pkg::t_cfg_index CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic        found;
        logic [32:0] offset;
    } t_translation;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE
    } t_rx_mode;

    // Clock and reset
    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    // Stimulus side
    logic                             s_valid   = 1'b0;
    logic [satfo_pkg::S_TDATA_W-1:0]  s_data    = '0;
    logic [satfo_pkg::S_TUSER_W-1:0]  s_user    = '0;
    logic                             m_ready   = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic [satfo_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [satfo_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Block outputs
    logic                             o_s_axis_tready;
    logic                             o_m_axis_tvalid;
    logic [satfo_pkg::M_TDATA_W-1:0]  o_m_axis_tdata;
    logic [satfo_pkg::M_TUSER_W-1:0]  o_m_axis_tuser;
    logic                             o_cfg_ready;

    // Local image of the block
    satfo_pkg::t_sect descriptors [TABLE_DEPTH];
    logic [7:0]  section_count;
    logic [4:0]  file_align;
    logic [4:0]  section_align;

    t_translation due_results [$];
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          burst_left     = 1;
    bit          steady_send    = 1'b0;
    bit          hold_req       = 1'b0;
    int          cycle_count    = 0;

    section_address_to_file_offset u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // Free-running clock, 8 ns period
    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Translation predictor
    // ------------------------------------------------------------------------
    function automatic logic [31:0] align_to_grain(input logic [31:0] value,
                                                   input logic [4:0] lg);
        logic [31:0] grain;
        grain = 32'd1 << lg;
        return (value + (grain - 32'd1)) & ~(grain - 32'd1);
    endfunction

    function automatic logic [31:0] section_span(input satfo_pkg::t_sect d);
        logic [31:0] raw;
        logic [31:0] virt;
        raw = align_to_grain(d.rsize, file_align);
        if (d.vsize != 32'd0) begin
            virt = (d.vsize + satfo_pkg::PAGE_MASK) & ~satfo_pkg::PAGE_MASK;
            return (virt < raw) ? virt : raw;
        end
        return raw;
    endfunction

    function automatic t_translation translate_address(input logic [31:0] va);
        t_translation r;
        int           n;
        bit           walk_done;
        logic [31:0]  span_end;
        logic [31:0]  raw_start;
        r = '0;
        walk_done = 1'b0;
        n = (section_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(section_count);
        if (n == 0) begin
            r.found  = 1'b1;
            r.offset = {1'b0, va};
        end
        for (int i = 0; i < n && !walk_done; i++) begin
            if (va < descriptors[i].base) begin
                // Below the first section passes unchanged, below a later one fails
                if (i == 0) begin
                    r.found  = 1'b1;
                    r.offset = {1'b0, va};
                end
                walk_done = 1'b1;
            end else if (descriptors[i].rptr != 32'd0) begin
                span_end = descriptors[i].base + section_span(descriptors[i]);
                if (va < span_end) begin
                    raw_start = descriptors[i].rptr;
                    if (section_align >= satfo_pkg::PAGE_ALIGN_LOG2)
                        raw_start = raw_start & ~satfo_pkg::RAW_GRAIN_MASK;
                    r.found  = 1'b1;
                    r.offset = {1'b0, va - descriptors[i].base} + {1'b0, raw_start};
                    walk_done = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic satfo_pkg::t_sect make_sect(input logic [31:0] base,
                                                   input logic [31:0] vsize,
                                                   input logic [31:0] rsize,
                                                   input logic [31:0] rptr);
        satfo_pkg::t_sect d;
        d.base  = base;
        d.vsize = vsize;
        d.rsize = rsize;
        d.rptr  = rptr;
        return d;
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return $urandom;
            2: return 32'hFFFF_F000 + $urandom_range(0, 32'hFFF);
            default: return $urandom_range(1, 32'h4000);
        endcase
    endfunction

    function automatic logic [31:0] pick_pointer();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return $urandom;
            default: return $urandom_range(1, 32'h0010_0000);
        endcase
    endfunction

    function automatic satfo_pkg::t_sect random_sect();
        return make_sect($urandom, pick_size(), pick_size(), pick_pointer());
    endfunction

    // Query near a section edge most of the time, anywhere otherwise
    function automatic logic [31:0] pick_query();
        int               n;
        satfo_pkg::t_sect d;
        logic [31:0]      span;
        n = (section_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(section_count);
        if (n == 0)
            return $urandom;
        d = descriptors[$urandom_range(0, n - 1)];
        span = section_span(d);
        case ($urandom_range(0, 7))
            0: return d.base;
            1: return d.base - 32'd1;
            2: return d.base + ((span == 32'd0) ? 32'd0 : $urandom_range(0, span - 32'd1));
            3: return d.base + span - 32'd1;
            4: return d.base + span;
            5: return $urandom;
            6: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            default: return d.base + $urandom_range(0, 32'hFFF);
        endcase
    endfunction

    // Offer one item and record its prediction once the transaction completes
    task automatic send_item(input satfo_pkg::t_cmd cmd, input logic [6:0] slot,
                             input satfo_pkg::t_sect d, input logic [31:0] query);
        int gap;
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {1'b0, query, d.rptr, d.rsize, d.vsize, d.base, slot};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (cmd == satfo_pkg::CMD_WRITE) begin
            descriptors[slot] = d;
            due_results.push_back('0);
        end else begin
            due_results.push_back(translate_address(query));
        end
        items_sent++;
        burst_left--;
        // Close the burst with a random gap
        if (!steady_send && burst_left <= 0) begin
            gap = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            @(negedge i_clk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Unused fields carry random content
    task automatic write_entry(input logic [6:0] slot, input satfo_pkg::t_sect d);
        send_item(satfo_pkg::CMD_WRITE, slot, d, $urandom);
    endtask

    task automatic translate(input logic [31:0] query);
        send_item(satfo_pkg::CMD_TRANSLATE, 7'($urandom_range(0, TABLE_DEPTH - 1)),
                  random_sect(), query);
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic wait_drain();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input satfo_pkg::t_cfg_index idx, input logic [7:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        case (idx)
            satfo_pkg::CFG_SECTION_COUNT: section_count = value;
            satfo_pkg::CFG_FILE_ALIGN:    file_align    = value[4:0];
            satfo_pkg::CFG_SECTION_ALIGN: section_align = value[4:0];
            default: ;
        endcase
    endtask

    // Increasing bases, with occasional overlaps and steps backward
    task automatic lay_out_sections(input int n);
        logic [31:0]      cursor;
        satfo_pkg::t_sect d;
        case ($urandom_range(0, 3))
            0: cursor = 32'd0;
            1: cursor = $urandom_range(1, 16) << 12;
            2: cursor = $urandom;
            default: cursor = 32'hFFFF_0000 + ($urandom_range(0, 15) << 12);
        endcase
        for (int i = 0; i < n; i++) begin
            d = make_sect(cursor, pick_size(), pick_size(), pick_pointer());
            write_entry(7'(i), d);
            case ($urandom_range(0, 9))
                0: cursor = cursor - $urandom_range(0, 32'h2000);
                1: cursor = cursor + $urandom_range(0, section_span(d));
                default: cursor = cursor + section_span(d) + ($urandom_range(0, 3) << 12);
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic fill_table();
        for (int i = 0; i < TABLE_DEPTH; i++)
            write_entry(7'(i), random_sect());
        wait_drain();
    endtask

    task automatic test_no_sections();
        translate(32'd0);
        translate(32'hFFFF_FFFF);
        translate($urandom);
        wait_drain();
    endtask

    // Default alignments; hand-built table covers each walk outcome
    task automatic test_directed_walk();
        write_register(satfo_pkg::CFG_SECTION_COUNT, 8'd5);
        write_entry(0, make_sect(32'h0000_1000, 32'h1800, 32'h1000, 32'h400));
        // no raw data: skipped
        write_entry(1, make_sect(32'h0000_3000, 32'h0, 32'h300, 32'h0));
        // zero virtual size: raw size alone, pointer rounded down
        write_entry(2, make_sect(32'h0000_3000, 32'h0, 32'h201, 32'h1234));
        // raw size rounding wraps to zero
        write_entry(3, make_sect(32'hFFFF_F000, 32'h2000, 32'hFFFF_FFFF, 32'h800));
        // span end wraps past the top of the address space
        write_entry(4, make_sect(32'hFFFF_F000, 32'h2000, 32'h2000, 32'hFFFF_FFFF));
        translate(32'h0000_0FFF);
        translate(32'h0000_1000);
        translate(32'h0000_1FFF);
        translate(32'h0000_2000);
        translate(32'h0000_3000);
        translate(32'h0000_33FF);
        translate(32'h0000_3400);
        translate(32'hFFFF_F800);
        translate(32'hFFFF_FFFF);
        wait_drain();
    endtask

    task automatic test_alignment_settings();
        write_register(satfo_pkg::CFG_SECTION_ALIGN, 8'd11);
        translate(32'h0000_3000);
        wait_drain();
        write_register(satfo_pkg::CFG_SECTION_ALIGN, 8'd31);
        write_register(satfo_pkg::CFG_FILE_ALIGN, 8'd0);
        translate(32'h0000_3200);
        wait_drain();
        write_register(satfo_pkg::CFG_SECTION_ALIGN, 8'd0);
        write_register(satfo_pkg::CFG_FILE_ALIGN, 8'd16);
        translate(32'h0000_2800);
        translate(32'h0000_3200);
        wait_drain();
        write_register(satfo_pkg::CFG_FILE_ALIGN, 8'd31);
        translate(32'hFFFF_F000);
        wait_drain();
        // Unmapped index leaves every register alone
        write_register(CFG_UNMAPPED, 8'hFF);
        translate(32'h0000_1800);
        wait_drain();
    endtask

    // Raw pointer near the top gives an offset wider than 32 bits
    task automatic test_wide_offset();
        write_register(satfo_pkg::CFG_SECTION_COUNT, 8'd1);
        write_register(satfo_pkg::CFG_FILE_ALIGN, 8'd9);
        write_entry(0, make_sect(32'h0, 32'h1_0000, 32'h1_0000, 32'hFFFF_FFFF));
        translate(32'h0000_FFFF);
        translate(32'h0001_0000);
        wait_drain();
        write_register(satfo_pkg::CFG_SECTION_ALIGN, 8'd12);
        translate(32'h0000_FFFF);
        wait_drain();
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        write_register(satfo_pkg::CFG_SECTION_COUNT, 8'd3);
        lay_out_sections(3);
        wait_drain();
        hold_req = 1'b1;
        steady_send = 1'b1;
        for (int i = 0; i < 20; i++)
            translate(pick_query());
        steady_send = 1'b0;
        wait_drain();
    endtask

    task automatic test_random_phases();
        int start_count;
        int walk_len;
        int queries;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0: write_register(satfo_pkg::CFG_SECTION_COUNT, 8'd0);
                1: write_register(satfo_pkg::CFG_SECTION_COUNT, 8'd128);
                2: write_register(satfo_pkg::CFG_SECTION_COUNT, 8'($urandom_range(129, 255)));
                3: write_register(satfo_pkg::CFG_SECTION_COUNT, 8'($urandom_range(13, 127)));
                default: write_register(satfo_pkg::CFG_SECTION_COUNT,
                                        8'($urandom_range(1, 12)));
            endcase
            case ($urandom_range(0, 3))
                0: write_register(satfo_pkg::CFG_FILE_ALIGN, 8'd9);
                1: write_register(satfo_pkg::CFG_FILE_ALIGN, 8'($urandom_range(17, 31)));
                default: write_register(satfo_pkg::CFG_FILE_ALIGN, 8'($urandom_range(0, 16)));
            endcase
            case ($urandom_range(0, 3))
                0: write_register(satfo_pkg::CFG_SECTION_ALIGN, 8'd12);
                1: write_register(satfo_pkg::CFG_SECTION_ALIGN, 8'd11);
                default: write_register(satfo_pkg::CFG_SECTION_ALIGN,
                                        8'($urandom_range(0, 31)));
            endcase
            if ($urandom_range(0, 9) == 0)
                write_register(CFG_UNMAPPED, 8'($urandom_range(0, 255)));
            walk_len = (section_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(section_count);
            lay_out_sections(walk_len);
            queries = (walk_len > 12) ? $urandom_range(6, 10) : $urandom_range(10, 30);
            for (int i = 0; i < queries; i++) begin
                // Occasional stray write scrambles the layout
                if ($urandom_range(0, 9) == 0)
                    write_entry(7'($urandom_range(0, TABLE_DEPTH - 1)), random_sect());
                translate(pick_query());
            end
            wait_drain();
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver stall pattern, with a long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_ready
        static int       hold_left  = 0;
        static int       stretch    = 0;
        static t_rx_mode rx_mode    = RX_OPEN;
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (stretch <= 0) begin
                case ($urandom_range(0, 3))
                    0, 1:    rx_mode = RX_OPEN;
                    2:       rx_mode = RX_RANDOM;
                    default: rx_mode = RX_SPARSE;
                endcase
                stretch = $urandom_range(20, 200);
            end
            stretch--;
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_RANDOM: m_ready <= ($urandom_range(0, 1) == 0);
                default:   m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Compare each result transaction with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_translation want;
        if (rst_n && o_m_axis_tvalid && m_ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, found %0d offset %h", $time,
                         o_m_axis_tuser[0], o_m_axis_tdata[satfo_pkg::OFFSET_W-1:0]);
                mismatch_count++;
            end else begin
                want = due_results.pop_front();
                if (o_m_axis_tuser[0] !== want.found) begin
                    $display("%0t: found mismatch, expected %0d, actual %0d", $time,
                             want.found, o_m_axis_tuser[0]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[satfo_pkg::OFFSET_W-1:0] !== want.offset) begin
                    $display("%0t: file_offset mismatch, expected %h, actual %h", $time,
                             want.offset, o_m_axis_tdata[satfo_pkg::OFFSET_W-1:0]);
                    mismatch_count++;
                end
            end
        end
    end

    // Guard against a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        section_count = satfo_pkg::RST_SECTION_COUNT;
        file_align    = satfo_pkg::RST_FILE_ALIGN;
        section_align = satfo_pkg::RST_SECTION_ALIGN;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        fill_table();
        test_no_sections();
        test_directed_walk();
        test_alignment_settings();
        test_wide_offset();
        test_backpressure();
        test_random_phases();

        wait_drain();
        if (mismatch_count == 0 && due_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
